/* hw/rtl/ptc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants of the pressure/temperature compensation
// Field widths, calibration register codes and the split 64-bit multiply.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned RawW    = 20;
  localparam int unsigned WordW   = 32;
  localparam int unsigned DataW   = 64;
  localparam int unsigned CalW    = 16;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PnW     = 21;

  localparam logic [DataW-1:0] TempOffset = 64'd128000;
  localparam logic [DataW-1:0] PressScale = 64'd3125;
  localparam logic [PnW-1:0]   PressBase  = 21'd1048576;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTempP1 = 2'd0,
    CfgP2P5   = 2'd1,
    CfgP6P9   = 2'd2
  } cfg_idx_e;

  // Partial products of a 64 x 64 product kept modulo 2^64
  typedef struct packed {
    logic [DataW-1:0] lo;
    logic [WordW-1:0] c1;
    logic [WordW-1:0] c2;
  } pp_t;

  function automatic pp_t mul_pp(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    logic [WordW-1:0] al;
    logic [WordW-1:0] ah;
    logic [WordW-1:0] bl;
    logic [WordW-1:0] bh;
    pp_t              r;
    al   = a[WordW-1:0];
    ah   = a[DataW-1:WordW];
    bl   = b[WordW-1:0];
    bh   = b[DataW-1:WordW];
    r.lo = DataW'(al) * DataW'(bl);
    r.c1 = al * bh;
    r.c2 = ah * bl;
    return r;
  endfunction

  function automatic logic [DataW-1:0] pp_sum(input pp_t p);
    logic [WordW-1:0] hi;
    hi = p.c1 + p.c2;
    return p.lo + {hi, {WordW{1'b0}}};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ptc_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_in_if / ptc_out_if: valid/ready channels of the compensation unit
// One beat carries the six raw bytes in, or one compensated result out.
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ptc_pkg::ByteW-1:0]  press_msb;
  logic [ptc_pkg::ByteW-1:0]  press_lsb;
  logic [ptc_pkg::ByteW-1:0]  press_xlsb;
  logic [ptc_pkg::ByteW-1:0]  temp_msb;
  logic [ptc_pkg::ByteW-1:0]  temp_lsb;
  logic [ptc_pkg::ByteW-1:0]  temp_xlsb;

  modport source (output valid, press_msb, press_lsb, press_xlsb,
                  temp_msb, temp_lsb, temp_xlsb, input ready);
  modport sink   (input valid, press_msb, press_lsb, press_xlsb,
                  temp_msb, temp_lsb, temp_xlsb, output ready);
endinterface

interface ptc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ptc_pkg::WordW-1:0]  fine_temp;
  logic signed [ptc_pkg::WordW-1:0]  temp_centi;
  logic        [ptc_pkg::WordW-1:0]  pressure_q24_8;
  logic                              pressure_valid;

  modport source (output valid, fine_temp, temp_centi, pressure_q24_8,
                  pressure_valid, input ready);
  modport sink   (input valid, fine_temp, temp_centi, pressure_q24_8,
                  pressure_valid, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ptc_sdiv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_sdiv: pipelined signed division, truncating toward zero
// One quotient bit per stage on magnitudes, sign fixed in the last stage.
// ----------------------------------------------------------------------------
module ptc_sdiv #(
  parameter int unsigned W     = ptc_pkg::DataW,
  parameter int unsigned SideW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [W-1:0]     num_i,
  input  wire logic [W-1:0]     den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output logic [W-1:0]          quot_o,
  output logic [SideW-1:0]      side_o
);

  typedef struct packed {
    logic [W-1:0]     rem;
    logic [W-1:0]     nq;   // dividend shifts out, quotient shifts in
    logic [W-1:0]     den;
    logic             neg;
    logic [SideW-1:0] side;
  } stg_t;

  stg_t             st_q [W+1];
  stg_t             st0_d;
  logic [W+1:0]     vld_q;
  logic [W-1:0]     quot_q;
  logic [SideW-1:0] side_q;

  always_comb begin
    st0_d.rem  = '0;
    st0_d.nq   = num_i[W-1] ? (-num_i) : num_i;
    st0_d.den  = den_i[W-1] ? (-den_i) : den_i;
    st0_d.neg  = num_i[W-1] ^ den_i[W-1];
    st0_d.side = side_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] rsh;
    logic [W:0] diff;
    stg_t       nxt;

    always_comb begin
      nxt     = st_q[i];
      rsh     = {st_q[i].rem, st_q[i].nq[W-1]};
      diff    = rsh - {1'b0, st_q[i].den};
      nxt.rem = diff[W] ? rsh[W-1:0] : diff[W-1:0];
      nxt.nq  = {st_q[i].nq[W-2:0], ~diff[W]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= st_q[W].neg ? (-st_q[W].nq) : st_q[W].nq;
      side_q <= st_q[W].side;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[W:0], valid_i};
    end
  end

  assign valid_o = vld_q[W+1];
  assign quot_o  = quot_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

/* hw/rtl/pressure_temp_compensation_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_temp_compensation_unit: barometric sensor compensation pipeline
// Builds raw 20-bit samples from six bytes and applies the integer
// compensation: fine temperature, centidegrees and pressure in Q24.8 Pa.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        beat contents
//  in_i      in    valid/ready      six raw result bytes
//  out_o     out   valid/ready      fine_temp, temp_centi, pressure, flag
//  cfg       in    cfg_we_i only    three 64-bit calibration registers
//
//  One beat enters per cycle while the output is not stalled; a result passes
//  through 14 front stages, 66 divider stages, 6 back stages and the output
//  register. The divider retires one quotient bit per stage.
//  A stalled output freezes every stage together; nothing is dropped.
//  Reset clears valid bits and calibration registers only.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  ptc_in_if.sink                              in_i,
  ptc_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [ptc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [ptc_pkg::CfgW-1:0]       cfg_data_i
);

  localparam int unsigned FrontN = 14;
  localparam int unsigned BackN  = 6;
  localparam int unsigned DW     = ptc_pkg::DataW;
  localparam int unsigned WW     = ptc_pkg::WordW;
  localparam int unsigned SideW  = 2 * WW + 1;

  typedef struct packed {
    logic [ptc_pkg::RawW-1:0] adc_p;
    logic [WW-1:0]            a;
    logic [WW-1:0]            d;
    logic [WW-1:0]            m1;
    logic [WW-1:0]            dd;
    logic [WW-1:0]            v1;
    logic [WW-1:0]            e;
    logic [WW-1:0]            m2;
    logic [WW-1:0]            tf;
    logic [WW-1:0]            tc;
    logic [ptc_pkg::PnW-1:0]  pn;
    logic [DW-1:0]            x;
    ptc_pkg::pp_t             pp0;
    ptc_pkg::pp_t             pp1;
    ptc_pkg::pp_t             pp2;
    logic [DW-1:0]            xx;
    logic [DW-1:0]            xp5;
    logic [DW-1:0]            xp2;
    logic [DW-1:0]            y0;
    logic [DW-1:0]            y1;
    logic [DW-1:0]            z1;
    logic [DW-1:0]            y;
    logic [DW-1:0]            xs;
    logic [DW-1:0]            nm;
    logic [DW-1:0]            w;
    logic [DW-1:0]            x2;
    logic [DW-1:0]            num;
    logic                     nz;
  } front_t;

  typedef struct packed {
    logic [DW-1:0] q;
    logic [DW-1:0] ps;
    ptc_pkg::pp_t  pp0;
    ptc_pkg::pp_t  pp1;
    logic [DW-1:0] t9;
    logic [DW-1:0] t8;
    logic [DW-1:0] c1;
    logic [DW-1:0] c2;
    logic [DW-1:0] s;
    logic [DW-1:0] pv;
    logic [WW-1:0] tf;
    logic [WW-1:0] tc;
    logic          nz;
  } back_t;

  typedef struct packed {
    logic [WW-1:0] fine_temp;
    logic [WW-1:0] temp_centi;
    logic [WW-1:0] pressure;
    logic          pressure_valid;
  } res_t;

  function automatic logic [DW-1:0] sx64(input logic [ptc_pkg::CalW-1:0] v);
    return {{(DW - ptc_pkg::CalW){v[ptc_pkg::CalW-1]}}, v};
  endfunction

  // Calibration registers
  logic [ptc_pkg::CfgW-1:0] cal_tp1_q, cal_p25_q, cal_p69_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_tp1_q <= '0;
      cal_p25_q <= '0;
      cal_p69_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptc_pkg::CfgTempP1: cal_tp1_q <= cfg_data_i;
        ptc_pkg::CfgP2P5:   cal_p25_q <= cfg_data_i;
        ptc_pkg::CfgP6P9:   cal_p69_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [ptc_pkg::CalW-1:0] t1;
  logic [WW-1:0]            t2x, t3x;
  logic [DW-1:0]            p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

  assign t1  = cal_tp1_q[15:0];
  assign t2x = {{(WW - ptc_pkg::CalW){cal_tp1_q[31]}}, cal_tp1_q[31:16]};
  assign t3x = {{(WW - ptc_pkg::CalW){cal_tp1_q[47]}}, cal_tp1_q[47:32]};
  assign p1x = {{(DW - ptc_pkg::CalW){1'b0}}, cal_tp1_q[63:48]};
  assign p2x = sx64(cal_p25_q[15:0]);
  assign p3x = sx64(cal_p25_q[31:16]);
  assign p4x = sx64(cal_p25_q[47:32]);
  assign p5x = sx64(cal_p25_q[63:48]);
  assign p6x = sx64(cal_p69_q[15:0]);
  assign p7x = sx64(cal_p69_q[31:16]);
  assign p8x = sx64(cal_p69_q[47:32]);
  assign p9x = sx64(cal_p69_q[63:48]);

  // Pipeline advance: all stages move together unless the output is held
  logic adv;
  logic out_vld_q;
  res_t out_q, out_d;

  assign adv        = ~out_vld_q | out_o.ready;
  assign in_i.ready = adv;

  // Front end: temperature and the pressure divisor / dividend
  front_t             f_q [1:FrontN];
  front_t             f_d [1:FrontN];
  logic [FrontN:1]    fv_q;
  logic [ptc_pkg::RawW-1:0] adc_t;
  logic [WW-1:0]      tf5;

  assign adc_t = {in_i.temp_msb, in_i.temp_lsb, in_i.temp_xlsb[7:ptc_pkg::NibW]};
  assign tf5   = f_q[5].tf + {f_q[5].tf[WW-3:0], 2'b00} + 32'd128;

  always_comb begin
    f_d[1]       = '0;
    f_d[1].adc_p = {in_i.press_msb, in_i.press_lsb, in_i.press_xlsb[7:ptc_pkg::NibW]};
    f_d[1].a     = WW'(adc_t >> 3) - WW'({t1, 1'b0});
    f_d[1].d     = WW'(adc_t >> 4) - WW'(t1);

    f_d[2]    = f_q[1];
    f_d[2].m1 = f_q[1].a * t2x;
    f_d[2].dd = f_q[1].d * f_q[1].d;

    f_d[3]    = f_q[2];
    f_d[3].v1 = WW'($signed(f_q[2].m1) >>> 11);
    f_d[3].e  = WW'($signed(f_q[2].dd) >>> 12);

    f_d[4]    = f_q[3];
    f_d[4].m2 = f_q[3].e * t3x;

    f_d[5]    = f_q[4];
    f_d[5].tf = f_q[4].v1 + WW'($signed(f_q[4].m2) >>> 14);

    f_d[6]    = f_q[5];
    f_d[6].tc = WW'($signed(tf5) >>> 8);
    f_d[6].x  = {{(DW - WW){f_q[5].tf[WW-1]}}, f_q[5].tf} - ptc_pkg::TempOffset;
    f_d[6].pn = ptc_pkg::PressBase - ptc_pkg::PnW'(f_q[5].adc_p);

    f_d[7]     = f_q[6];
    f_d[7].pp0 = ptc_pkg::mul_pp(f_q[6].x, f_q[6].x);
    f_d[7].pp1 = ptc_pkg::mul_pp(f_q[6].x, p5x);
    f_d[7].pp2 = ptc_pkg::mul_pp(f_q[6].x, p2x);

    f_d[8]     = f_q[7];
    f_d[8].xx  = ptc_pkg::pp_sum(f_q[7].pp0);
    f_d[8].xp5 = ptc_pkg::pp_sum(f_q[7].pp1);
    f_d[8].xp2 = ptc_pkg::pp_sum(f_q[7].pp2);

    f_d[9]     = f_q[8];
    f_d[9].pp0 = ptc_pkg::mul_pp(f_q[8].xx, p6x);
    f_d[9].pp1 = ptc_pkg::mul_pp(f_q[8].xx, p3x);
    f_d[9].y0  = (f_q[8].xp5 << 17) + (p4x << 35);
    f_d[9].xp2 = f_q[8].xp2 << 12;

    f_d[10]    = f_q[9];
    f_d[10].y1 = ptc_pkg::pp_sum(f_q[9].pp0);
    f_d[10].z1 = ptc_pkg::pp_sum(f_q[9].pp1);

    f_d[11]    = f_q[10];
    f_d[11].y  = f_q[10].y1 + f_q[10].y0;
    f_d[11].xs = DW'($signed(f_q[10].z1) >>> 8) + f_q[10].xp2;

    f_d[12]     = f_q[11];
    f_d[12].pp0 = ptc_pkg::mul_pp((DW'(1) << 47) + f_q[11].xs, p1x);
    f_d[12].nm  = (DW'(f_q[11].pn) << 31) - f_q[11].y;

    f_d[13]     = f_q[12];
    f_d[13].w   = ptc_pkg::pp_sum(f_q[12].pp0);
    f_d[13].pp1 = ptc_pkg::mul_pp(f_q[12].nm, ptc_pkg::PressScale);

    f_d[14]     = f_q[13];
    f_d[14].x2  = DW'($signed(f_q[13].w) >>> 33);
    f_d[14].num = ptc_pkg::pp_sum(f_q[13].pp1);
    f_d[14].nz  = (DW'($signed(f_q[13].w) >>> 33) != '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_q <= f_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (adv) begin
      fv_q <= {fv_q[FrontN-1:1], in_i.valid};
    end
  end

  // Division of the scaled dividend by the pressure divisor
  logic             div_vld;
  logic [DW-1:0]    div_q;
  logic [SideW-1:0] div_side;

  ptc_sdiv #(
    .W     (DW),
    .SideW (SideW)
  ) u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fv_q[FrontN]),
    .num_i   (f_q[FrontN].num),
    .den_i   (f_q[FrontN].x2),
    .side_i  ({f_q[FrontN].tf, f_q[FrontN].tc, f_q[FrontN].nz}),
    .valid_o (div_vld),
    .quot_o  (div_q),
    .side_o  (div_side)
  );

  // Back end: second-order pressure correction
  back_t          b_q [1:BackN];
  back_t          b_d [1:BackN];
  logic [BackN:1] bv_q;

  always_comb begin
    b_d[1]                            = '0;
    b_d[1].q                          = div_q;
    {b_d[1].tf, b_d[1].tc, b_d[1].nz} = div_side;
    b_d[1].ps                         = DW'($signed(div_q) >>> 13);
    b_d[1].pp0                        = ptc_pkg::mul_pp(p9x, DW'($signed(div_q) >>> 13));
    b_d[1].pp1                        = ptc_pkg::mul_pp(p8x, div_q);

    b_d[2]    = b_q[1];
    b_d[2].t9 = ptc_pkg::pp_sum(b_q[1].pp0);
    b_d[2].t8 = ptc_pkg::pp_sum(b_q[1].pp1);

    b_d[3]     = b_q[2];
    b_d[3].pp0 = ptc_pkg::mul_pp(b_q[2].t9, b_q[2].ps);
    b_d[3].c2  = DW'($signed(b_q[2].t8) >>> 19);

    b_d[4]    = b_q[3];
    b_d[4].c1 = DW'($signed(ptc_pkg::pp_sum(b_q[3].pp0)) >>> 25);

    b_d[5]   = b_q[4];
    b_d[5].s = b_q[4].q + b_q[4].c1 + b_q[4].c2;

    b_d[6]    = b_q[5];
    b_d[6].pv = DW'($signed(b_q[5].s) >>> 8) + (p7x << 4);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q <= b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else if (adv) begin
      bv_q <= {bv_q[BackN-1:1], div_vld};
    end
  end

  // Saturate and register the result; zero divisor forces pressure to 0
  always_comb begin
    out_d.fine_temp      = b_q[BackN].tf;
    out_d.temp_centi     = b_q[BackN].tc;
    out_d.pressure_valid = b_q[BackN].nz;
    if (!b_q[BackN].nz || b_q[BackN].pv[DW-1]) begin
      out_d.pressure = '0;
    end else if (|b_q[BackN].pv[DW-1:WW]) begin
      out_d.pressure = '1;
    end else begin
      out_d.pressure = b_q[BackN].pv[WW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= bv_q[BackN];
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.fine_temp      = out_q.fine_temp;
  assign out_o.temp_centi     = out_q.temp_centi;
  assign out_o.pressure_q24_8 = out_q.pressure;
  assign out_o.pressure_valid = out_q.pressure_valid;

endmodule
`default_nettype wire

/* tb/sv/pressure_temp_compensation_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation_unit_tb: self-checking bench of the compensation
// Drives raw conversion bytes under several calibration sets, predicts the
// temperature and pressure results in 32/64-bit integer arithmetic and checks
// every output beat in order, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_unit_tb;

  localparam logic [ptc_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 120;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [7:0] p_msb, p_lsb, p_xlsb, t_msb, t_lsb, t_xlsb;
  } raw_beat_t;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] centi;
    logic [31:0] press;
    logic        pvalid;
  } comp_res_t;

  class comp_scoreboard;
    logic [63:0] cal [3];
    comp_res_t   pending [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned invalid_seen;

    // calibration registers come out of reset as zero
    function new();
      foreach (cal[i]) cal[i] = '0;
    endfunction

    function void set_cal(logic [ptc_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
      if (idx <= ptc_pkg::CfgP6P9) cal[idx] = val;
    endfunction

    function comp_res_t compensate(raw_beat_t b);
      int        adc_t, adc_p, t1, t2, t3, a, d, v1, v2, tf;
      longint    p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint    x, y, x2, den, num, q, ps, c1, c2, pv;
      comp_res_t r;
      adc_t = int'({b.t_msb, b.t_lsb, b.t_xlsb[7:4]});
      adc_p = int'({b.p_msb, b.p_lsb, b.p_xlsb[7:4]});
      t1 = {16'd0, cal[0][15:0]};
      t2 = int'($signed(cal[0][31:16]));
      t3 = int'($signed(cal[0][47:32]));
      p1 = longint'({48'd0, cal[0][63:48]});
      p2 = longint'($signed(cal[1][15:0]));
      p3 = longint'($signed(cal[1][31:16]));
      p4 = longint'($signed(cal[1][47:32]));
      p5 = longint'($signed(cal[1][63:48]));
      p6 = longint'($signed(cal[2][15:0]));
      p7 = longint'($signed(cal[2][31:16]));
      p8 = longint'($signed(cal[2][47:32]));
      p9 = longint'($signed(cal[2][63:48]));
      a  = (adc_t >>> 3) - (t1 <<< 1);
      v1 = (a * t2) >>> 11;
      d  = (adc_t >>> 4) - t1;
      v2 = (((d * d) >>> 12) * t3) >>> 14;
      tf = v1 + v2;
      r.fine  = tf;
      r.centi = (tf * 5 + 128) >>> 8;
      x   = longint'(tf) - 128000;
      y   = x * x * p6 + ((x * p5) <<< 17) + (p4 <<< 35);
      x2  = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
      den = (((longint'(1) <<< 47) + x2) * p1) >>> 33;
      r.press  = '0;
      r.pvalid = 1'b0;
      if (den != 0) begin
        num = (((longint'(1048576) - adc_p) <<< 31) - y) * 3125;
        // most negative over -1 wraps back
        q  = (den == -1) ? -num : num / den;
        ps = q >>> 13;
        c1 = (p9 * ps * ps) >>> 25;
        c2 = (p8 * q) >>> 19;
        pv = ((q + c1 + c2) >>> 8) + (p7 <<< 4);
        if (pv < 0) r.press = '0;
        else if (pv > longint'(64'hFFFF_FFFF)) r.press = '1;
        else r.press = pv[31:0];
        r.pvalid = 1'b1;
      end
      return r;
    endfunction

    function void note_input(raw_beat_t b);
      pending.push_back(compensate(b));
    endfunction

    function void check_result(comp_res_t got);
      comp_res_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat fine=%h centi=%h press=%h v=%b",
                 $time, got.fine, got.centi, got.press, got.pvalid);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (!want.pvalid) invalid_seen++;
      if (got.fine !== want.fine) begin
        $display("%0t: fine_temp exp %h got %h", $time, want.fine, got.fine);
        errors++;
      end
      if (got.centi !== want.centi) begin
        $display("%0t: temp_centi exp %h got %h", $time, want.centi, got.centi);
        errors++;
      end
      if (got.press !== want.press) begin
        $display("%0t: pressure_q24_8 exp %h got %h", $time, want.press, got.press);
        errors++;
      end
      if (got.pvalid !== want.pvalid) begin
        $display("%0t: pressure_valid exp %b got %b", $time, want.pvalid, got.pvalid);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ptc_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ptc_pkg::CfgW-1:0] cfg_data_i = '0;

  ptc_in_if  in_if ();
  ptc_out_if out_if ();

  pressure_temp_compensation_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  comp_scoreboard sb = new();
  bit          quiet;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned cycles;
  int unsigned beats_sent;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    {in_if.press_msb, in_if.press_lsb, in_if.press_xlsb} = '0;
    {in_if.temp_msb, in_if.temp_lsb, in_if.temp_xlsb} = '0;
    out_if.ready = 1'b0;
  end

  // receiver side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (quiet) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_input({in_if.press_msb, in_if.press_lsb, in_if.press_xlsb,
                     in_if.temp_msb, in_if.temp_lsb, in_if.temp_xlsb});
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result({out_if.fine_temp, out_if.temp_centi,
                       out_if.pressure_q24_8, out_if.pressure_valid});
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(raw_beat_t b);
    while (!quiet && $urandom_range(99) < 36) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.press_msb  <= b.p_msb;
    in_if.press_lsb  <= b.p_lsb;
    in_if.press_xlsb <= b.p_xlsb;
    in_if.temp_msb   <= b.t_msb;
    in_if.temp_lsb   <= b.t_lsb;
    in_if.temp_xlsb  <= b.t_xlsb;
    do @(posedge clk_i); while (!in_if.ready);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_cal(logic [ptc_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_cal(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // idle the input and let the pipeline empty out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic load_set(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2);
    write_cal(ptc_pkg::CfgTempP1, c0);
    write_cal(ptc_pkg::CfgP2P5, c1);
    write_cal(ptc_pkg::CfgP6P9, c2);
  endtask

  function automatic raw_beat_t rand_beat();
    raw_beat_t b;
    b = 48'({$urandom, $urandom});
    // bias some bytes toward the ends of their range
    if ($urandom_range(7) == 0) b.p_msb = $urandom_range(1) ? 8'hFF : 8'h00;
    if ($urandom_range(7) == 0) b.t_msb = $urandom_range(1) ? 8'hFF : 8'h00;
    return b;
  endfunction

  task automatic random_run(int unsigned n);
    repeat (n) send_beat(rand_beat());
  endtask

  initial begin
    raw_beat_t dir [$];
    @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset calibration: divisor is zero, pressure flagged invalid
    dir = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h655AC0_7EED00};
    foreach (dir[i]) send_beat(dir[i]);
    random_run(20);
    drain();

    // typical calibration words
    load_set({16'd36477, 16'hFC18, 16'd26435, 16'd27504},
             {16'd140, 16'd2855, 16'd3024, 16'hD643},
             {16'd6000, 16'hC6F8, 16'd15500, 16'hFFF9});
    write_cal(CfgUnused, '1);
    dir = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h655AC0_7EED00, 48'h655ACF_7EED0F,
            48'h800000_800000, 48'h7FFFF0_7FFFF0, 48'hAA55A0_55AA50,
            48'h00000F_FFFFF0, 48'hFFFFF0_00000F, 48'h5A5A5A_A5A5A5,
            48'h000010_000010, 48'h4E2000_6B1000, 48'h123450_876540};
    foreach (dir[i]) send_beat(dir[i]);
    random_run(100);
    hold_req = 1'b1;
    random_run(60);
    drain();

    // extremes of the calibration words
    load_set('1, '1, '1);
    random_run(80);
    drain();
    load_set(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
    random_run(60);
    drain();
    load_set(64'hFFFF_7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
    random_run(60);
    drain();

    // no idling on either side
    quiet = 1'b1;
    load_set({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    random_run(80);
    quiet = 1'b0;
    drain();

    // random calibration sets, one sender pause to an empty pipeline
    repeat (4) begin
      load_set({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      random_run(30);
      in_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clk_i);
      random_run(30);
      drain();
    end

    $display("%0d beats sent, %0d results checked (%0d with zero divisor)",
             beats_sent, sb.checked, sb.invalid_seen);
    $display("covered reset, typical, extreme and random calibration sets");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
